@@ src/lut_matrix_lut_color_convert_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the color convert core
// Clocked on clk; the first form is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LUT_MATRIX_LUT_COLOR_CONVERT_CORE_ASSERT_SVH
`define LUT_MATRIX_LUT_COLOR_CONVERT_CORE_ASSERT_SVH

// property checked outside reset only
`define LMLCC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// property checked at every edge, reset included
`define LMLCC_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

@@ src/lmlcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmlcc_pkg
// Shared sizes, codes and types of the matrix/TRC color convert core.
// ----------------------------------------------------------------------------
package lmlcc_pkg;

	// table geometry and fixed-point formats
	localparam int LUT_ENTRIES = 4096;
	localparam int LUT_AW      = $clog2(LUT_ENTRIES);
	localparam int FRAC_BITS   = 16;
	localparam int COEF_BITS   = 20;
	localparam int NUM_CH      = 3;
	localparam int ROW_W       = COEF_BITS * NUM_CH;
	localparam int SAMPLE_W    = 16;
	localparam int LIN_W       = FRAC_BITS + 1;
	localparam int ENC_W       = 16;
	localparam int TVAL_W      = 17;
	localparam int REQ_W       = 2;
	localparam int CH_W        = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = ROW_W;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [LIN_W-1:0]    lin_t;
	typedef logic [ENC_W-1:0]    enc_t;

	// 1.0 in linear format
	localparam lin_t LIN_ONE = lin_t'(1 << FRAC_BITS);

	typedef enum logic [REQ_W-1:0] {
		REQ_PIXEL,
		REQ_LIN_WRITE,
		REQ_ENC_WRITE
	} req_kind_t;

	typedef enum logic [CH_W-1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} channel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BYPASS,
		CFG_SAMPLE_DEPTH,
		CFG_ROW_RED,
		CFG_ROW_GREEN,
		CFG_ROW_BLUE
	} cfg_reg_t;

	// table write requests
	typedef struct packed {
		logic              en;
		logic [LUT_AW-1:0] addr;
		lin_t              data;
	} lin_wr_t;

	typedef struct packed {
		logic              en;
		logic [LUT_AW-1:0] addr;
		enc_t              data;
	} enc_wr_t;

endpackage

@@ src/lmlcc_if.sv @@
// ----------------------------------------------------------------------------
// lmlcc channel interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------

// request channel: pixels and table writes
interface lmlcc_req_if;
	logic                               valid;
	logic                               ready;
	logic [lmlcc_pkg::REQ_W-1:0]        req_type;
	logic [lmlcc_pkg::SAMPLE_W-1:0]     red_in;
	logic [lmlcc_pkg::SAMPLE_W-1:0]     green_in;
	logic [lmlcc_pkg::SAMPLE_W-1:0]     blue_in;
	logic [lmlcc_pkg::SAMPLE_W-1:0]     alpha_in;
	logic [lmlcc_pkg::CH_W-1:0]         table_channel;
	logic [lmlcc_pkg::LUT_AW-1:0]       table_index;
	logic [lmlcc_pkg::TVAL_W-1:0]       table_value;

	modport source (
		output valid, req_type, red_in, green_in, blue_in, alpha_in,
		       table_channel, table_index, table_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, red_in, green_in, blue_in, alpha_in,
		       table_channel, table_index, table_value,
		output ready
	);
endinterface

// response channel: converted pixels
interface lmlcc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [lmlcc_pkg::SAMPLE_W-1:0] red_out;
	logic [lmlcc_pkg::SAMPLE_W-1:0] green_out;
	logic [lmlcc_pkg::SAMPLE_W-1:0] blue_out;
	logic [lmlcc_pkg::SAMPLE_W-1:0] alpha_out;

	modport source (
		output valid, red_out, green_out, blue_out, alpha_out,
		input  ready
	);
	modport sink (
		input  valid, red_out, green_out, blue_out, alpha_out,
		output ready
	);
endinterface

// register write channel
interface lmlcc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lmlcc_pkg::CFG_IDX_W-1:0]  index;
	logic [lmlcc_pkg::CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

@@ src/lut_matrix_lut_color_convert_core.sv @@
// ----------------------------------------------------------------------------
// lut_matrix_lut_color_convert_core
// RGBA color conversion: per-channel linearize table, 3x3 matrix, encode table.
// ----------------------------------------------------------------------------
// Usage:
//   req carries pixel transactions and table-write transactions. A pixel
//   gives one rsp transaction; a linearize or encode table write gives none.
//   Tables must be written before pixels read them. cfg writes the bypass,
//   sample depth and matrix row registers; it is always ready. The user must
//   write it only while no pixel is in flight; the block does not enforce this.
// Pipeline: a pixel's req transaction passes the linearize RAM read, products,
//   row sum, encode RAM read and output register before rsp.valid rises.
// Throughput: one transaction per clock while rsp is not held. Each table
//   has one write and one read port; the encode table is kept in three
//   identical copies so the three rows look it up in the same cycle.
// Stall: a stage loads whenever it is empty or its content moves on, so
//   bubbles fill up while rsp is held and req keeps going until five
//   pixels are queued. rsp payload holds while rsp.ready is low.
// Reset: arst_n clears the pipeline valids and sets bypass, 8-bit samples
//   and an all-zero matrix. Table contents are not cleared.
// ----------------------------------------------------------------------------
module lut_matrix_lut_color_convert_core (
	input  logic        clk,
	input  logic        arst_n,
	lmlcc_cfg_if.sink   cfg,
	lmlcc_req_if.sink   req,
	lmlcc_rsp_if.source rsp
);

	localparam int NCH = lmlcc_pkg::NUM_CH;
	localparam int SW  = lmlcc_pkg::SAMPLE_W;
	localparam int AW  = lmlcc_pkg::LUT_AW;

	// 8-bit output: (enc + 128) / 257 as (x * 65281) >> 24
	localparam int ENC8_ROUND = 128;
	localparam int ENC8_RECIP = 65281;
	localparam int ENC8_SHIFT = 24;
	localparam int ENC8_X_W   = lmlcc_pkg::ENC_W + 1;
	localparam int ENC8_P_W   = 2 * ENC8_X_W;

	localparam lmlcc_pkg::channel_t CH_OF [NCH] =
		'{lmlcc_pkg::CH_RED, lmlcc_pkg::CH_GREEN, lmlcc_pkg::CH_BLUE};

	// configuration registers
	logic                                    bypass_q;
	logic                                    depth_q;
	logic [NCH-1:0][lmlcc_pkg::ROW_W-1:0]    rows_q;

	// pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ld1, ld2, ld3, ld4, ld5;
	logic acc;
	logic is_pix, is_lin_wr, is_enc_wr;

	// pipeline payload
	logic                   w_s1, w_s2, w_s3;
	logic [AW-1:0]          tidx_s1, tidx_s2, tidx_s3;
	lmlcc_pkg::enc_t        tval_s1, tval_s2, tval_s3;
	logic [NCH:0][SW-1:0]   px_s1, px_s2, px_s3, px_s4;
	logic [NCH:0][SW-1:0]   px_in;
	logic [NCH-1:0][SW-1:0] out_s5;
	logic [SW-1:0]          alpha_s5;

	// datapath between units
	lmlcc_pkg::lin_t [NCH-1:0] lin_s1;
	lmlcc_pkg::lin_t [NCH-1:0] level_s3;
	lmlcc_pkg::enc_t           enc_s4 [NCH];
	logic [NCH-1:0][SW-1:0]    conv;
	lmlcc_pkg::lin_wr_t        lin_wr [NCH];
	lmlcc_pkg::enc_wr_t        enc_wr;
	lmlcc_pkg::lin_t           lin_val;
	lmlcc_pkg::enc_t           enc_val;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b1;
			depth_q  <= 1'b0;
			rows_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (lmlcc_pkg::cfg_reg_t'(cfg.index))
				lmlcc_pkg::CFG_BYPASS:       bypass_q  <= cfg.data[0];
				lmlcc_pkg::CFG_SAMPLE_DEPTH: depth_q   <= cfg.data[0];
				lmlcc_pkg::CFG_ROW_RED:      rows_q[0] <= cfg.data;
				lmlcc_pkg::CFG_ROW_GREEN:    rows_q[1] <= cfg.data;
				lmlcc_pkg::CFG_ROW_BLUE:     rows_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// request decode
	assign is_pix    = lmlcc_pkg::req_kind_t'(req.req_type) == lmlcc_pkg::REQ_PIXEL;
	assign is_lin_wr = lmlcc_pkg::req_kind_t'(req.req_type) == lmlcc_pkg::REQ_LIN_WRITE;
	assign is_enc_wr = lmlcc_pkg::req_kind_t'(req.req_type) == lmlcc_pkg::REQ_ENC_WRITE;
	assign px_in     = {req.alpha_in, req.blue_in, req.green_in, req.red_in};

	// write values saturated: linearize at 1.0, encode at full scale
	assign lin_val = (req.table_value[16] && (|req.table_value[15:0])) ?
		lmlcc_pkg::LIN_ONE : req.table_value;
	assign enc_val = req.table_value[16] ? '1 : req.table_value[15:0];

	// load enables: a stage loads when empty or when its item moves on;
	// encode writes retire out of stage 3 without needing stage 4
	assign ld5 = !valid_s5 || rsp.ready;
	assign ld4 = !valid_s4 || ld5;
	assign ld3 = !valid_s3 || w_s3 || ld4;
	assign ld2 = !valid_s2 || ld3;
	assign ld1 = !valid_s1 || ld2;
	assign req.ready = ld1;
	assign acc = req.valid && ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= acc && (is_pix || is_enc_wr);
			if (ld2) valid_s2 <= valid_s1;
			if (ld3) valid_s3 <= valid_s2;
			if (ld4) valid_s4 <= valid_s3 && !w_s3;
			if (ld5) valid_s5 <= valid_s4;
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (ld1) begin
			w_s1    <= is_enc_wr;
			tidx_s1 <= req.table_index;
			tval_s1 <= enc_val;
			px_s1   <= px_in;
		end
		if (ld2) begin
			w_s2    <= w_s1;
			tidx_s2 <= tidx_s1;
			tval_s2 <= tval_s1;
			px_s2   <= px_s1;
		end
		if (ld3) begin
			w_s3    <= w_s2;
			tidx_s3 <= tidx_s2;
			tval_s3 <= tval_s2;
			px_s3   <= px_s2;
		end
		if (ld4) begin
			px_s4 <= px_s3;
		end
	end

	// linearize tables, written and read in request order at stage 1
	for (genvar c = 0; c < NCH; c++) begin : g_lin
		assign lin_wr[c].en   = acc && is_lin_wr && (req.table_channel == CH_OF[c]);
		assign lin_wr[c].addr = req.table_index;
		assign lin_wr[c].data = lin_val;

		lmlcc_lin_lut u_lin (
			.clk     (clk),
			.rd_en   (ld1),
			.depth16 (depth_q),
			.sample  (px_in[c]),
			.wr      (lin_wr[c]),
			.lin_s1  (lin_s1[c])
		);
	end

	// matrix
	lmlcc_matrix u_matrix (
		.clk      (clk),
		.ld_s2    (ld2),
		.ld_s3    (ld3),
		.lin      (lin_s1),
		.rows     (rows_q),
		.level_s3 (level_s3)
	);

	// encode tables: writes retire at stage 3, where pixels read, so
	// reads and writes keep request order without an interlock
	assign enc_wr.en   = valid_s3 && w_s3;
	assign enc_wr.addr = tidx_s3;
	assign enc_wr.data = tval_s3;

	for (genvar c = 0; c < NCH; c++) begin : g_enc
		lmlcc_enc_lut u_enc (
			.clk    (clk),
			.rd_en  (ld4),
			.level  (level_s3[c]),
			.wr     (enc_wr),
			.enc_s4 (enc_s4[c])
		);
	end

	// output scaling
	always_comb begin
		logic [ENC8_X_W-1:0] x;
		logic [ENC8_P_W-1:0] p;
		for (int c = 0; c < NCH; c++) begin
			x = ENC8_X_W'(enc_s4[c]) + ENC8_X_W'(ENC8_ROUND);
			p = ENC8_P_W'(x) * ENC8_P_W'(ENC8_RECIP);
			if (bypass_q) begin
				conv[c] = px_s4[c];
			end else if (depth_q) begin
				conv[c] = enc_s4[c];
			end else begin
				conv[c] = SW'(p[ENC8_P_W-1:ENC8_SHIFT]);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ld5) begin
			out_s5   <= conv;
			alpha_s5 <= px_s4[NCH];
		end
	end

	assign rsp.valid     = valid_s5;
	assign rsp.red_out   = out_s5[0];
	assign rsp.green_out = out_s5[1];
	assign rsp.blue_out  = out_s5[2];
	assign rsp.alpha_out = alpha_s5;

endmodule

@@ src/lmlcc_lin_lut.sv @@
// ----------------------------------------------------------------------------
// lmlcc_lin_lut
// One linearize table: sample to table index, synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module lmlcc_lin_lut (
	input  logic               clk,
	input  logic               rd_en,
	input  logic               depth16,
	input  lmlcc_pkg::sample_t sample,
	input  lmlcc_pkg::lin_wr_t wr,
	output lmlcc_pkg::lin_t    lin_s1
);

	localparam int AW = lmlcc_pkg::LUT_AW;

	lmlcc_pkg::lin_t mem [lmlcc_pkg::LUT_ENTRIES];

	logic [7:0]    s8;
	logic [15:0]   frac_prod;
	logic [AW-1:0] idx8;
	logic [AW-1:0] idx16;
	logic [AW-1:0] rd_addr;

	// 8-bit index v*4095/255 = 16*v + v/17; v/17 is (v*241)>>12 for v < 256
	assign s8        = sample[7:0];
	assign frac_prod = 16'(s8) * 16'd241;
	assign idx8      = {s8, {(AW-8){1'b0}}} + AW'(frac_prod[15:12]);

	// 16-bit index keeps the top bits
	assign idx16   = sample[lmlcc_pkg::SAMPLE_W-1 -: AW];
	assign rd_addr = depth16 ? idx16 : idx8;

	// table RAM, one write and one read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			lin_s1 <= mem[rd_addr];
		end
	end

endmodule

@@ src/lmlcc_matrix.sv @@
// ----------------------------------------------------------------------------
// lmlcc_matrix
// 3x3 signed Q4.16 matrix: registered products, then row sum and clamp.
// ----------------------------------------------------------------------------
module lmlcc_matrix (
	input  logic                                                   clk,
	input  logic                                                   ld_s2,
	input  logic                                                   ld_s3,
	input  lmlcc_pkg::lin_t [lmlcc_pkg::NUM_CH-1:0]                lin,
	input  logic [lmlcc_pkg::NUM_CH-1:0][lmlcc_pkg::ROW_W-1:0]     rows,
	output lmlcc_pkg::lin_t [lmlcc_pkg::NUM_CH-1:0]                level_s3
);

	localparam int NCH    = lmlcc_pkg::NUM_CH;
	localparam int CW     = lmlcc_pkg::COEF_BITS;
	localparam int FB     = lmlcc_pkg::FRAC_BITS;
	localparam int PROD_W = CW + lmlcc_pkg::LIN_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SH_W   = SUM_W - 1 - FB;

	logic signed [PROD_W-1:0] prod_s2 [NCH][NCH];
	logic signed [SUM_W-1:0]  sum     [NCH];
	logic        [SH_W-1:0]   shifted [NCH];
	lmlcc_pkg::lin_t          level   [NCH];

	// stage 2: nine products, coefficient times linear value
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			for (int r = 0; r < NCH; r++) begin
				for (int c = 0; c < NCH; c++) begin
					prod_s2[r][c] <= $signed(rows[r][c*CW +: CW])
						* $signed({1'b0, lin[c]});
				end
			end
		end
	end

	// row sum, drop fraction, clamp to 0..1.0
	always_comb begin
		for (int r = 0; r < NCH; r++) begin
			sum[r] = SUM_W'(prod_s2[r][0]) + SUM_W'(prod_s2[r][1])
				+ SUM_W'(prod_s2[r][2]);
			shifted[r] = sum[r][SUM_W-2:FB];
			if (sum[r][SUM_W-1]) begin
				level[r] = '0;
			end else if (shifted[r] > SH_W'(lmlcc_pkg::LIN_ONE)) begin
				level[r] = lmlcc_pkg::LIN_ONE;
			end else begin
				level[r] = shifted[r][lmlcc_pkg::LIN_W-1:0];
			end
		end
	end

	// stage 3 register
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			for (int r = 0; r < NCH; r++) begin
				level_s3[r] <= level[r];
			end
		end
	end

endmodule

@@ src/lmlcc_enc_lut.sv @@
// ----------------------------------------------------------------------------
// lmlcc_enc_lut
// One copy of the encode table: level to rounded index, RAM, registered read.
// ----------------------------------------------------------------------------
module lmlcc_enc_lut (
	input  logic               clk,
	input  logic               rd_en,
	input  lmlcc_pkg::lin_t    level,
	input  lmlcc_pkg::enc_wr_t wr,
	output lmlcc_pkg::enc_t    enc_s4
);

	localparam int AW    = lmlcc_pkg::LUT_AW;
	localparam int FB    = lmlcc_pkg::FRAC_BITS;
	localparam int SC_W  = lmlcc_pkg::LIN_W + AW;
	localparam int IDX_W = SC_W - FB;

	lmlcc_pkg::enc_t mem [lmlcc_pkg::LUT_ENTRIES];

	logic [SC_W-1:0]  scaled;
	logic [IDX_W-1:0] idx_full;
	logic [AW-1:0]    rd_addr;

	// (level*(entries-1) + half) >> frac, saturated to the last entry
	assign scaled   = (SC_W'(level) << AW) - SC_W'(level) + SC_W'(1 << (FB-1));
	assign idx_full = scaled[SC_W-1:FB];
	assign rd_addr  = (idx_full > IDX_W'(lmlcc_pkg::LUT_ENTRIES-1)) ?
		'1 : idx_full[AW-1:0];

	// table RAM, one write and one read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			enc_s4 <= mem[rd_addr];
		end
	end

endmodule

@@ src/lmlcc_checker.sv @@
// ----------------------------------------------------------------------------
// lmlcc_checker
// Port-level checks of the color convert core, bound to the top level.
// ----------------------------------------------------------------------------
`include "lut_matrix_lut_color_convert_core_assert.svh"

module lmlcc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [lmlcc_pkg::SAMPLE_W-1:0] rsp_red,
	input logic [lmlcc_pkg::SAMPLE_W-1:0] rsp_green,
	input logic [lmlcc_pkg::SAMPLE_W-1:0] rsp_blue,
	input logic [lmlcc_pkg::SAMPLE_W-1:0] rsp_alpha
);

	// a stalled result stays offered
	`LMLCC_ASSERT_RST(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped under stall")

	// and keeps its payload
	`LMLCC_ASSERT_RST(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_alpha), "rsp payload changed under stall")

	// with the output register empty nothing can block a request
	`LMLCC_ASSERT_RST(a_ready_when_drained, req_valid && !rsp_valid |-> req_ready, "req blocked with empty output")

	// reset empties the pipeline by the next edge
	`LMLCC_ASSERT_ANY(a_reset_clears, !arst_n |=> !rsp_valid, "rsp valid after reset")

endmodule

bind lut_matrix_lut_color_convert_core lmlcc_checker u_lmlcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_red   (rsp.red_out),
	.rsp_green (rsp.green_out),
	.rsp_blue  (rsp.blue_out),
	.rsp_alpha (rsp.alpha_out)
);
